@@ rtl/core/tsvfe_pkg.sv @@
// Shared constants and types for the TSV field escape codec.
// Used by tsvfe_decode and tsv_field_escape_codec; depends on nothing.
`timescale 1ns / 1ps

package tsvfe_pkg;

    // Character codes
    localparam logic [7:0] CH_BSL  = 8'h5C;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_T    = 8'h74;
    localparam logic [7:0] CH_N    = 8'h6E;
    localparam logic [7:0] CH_R    = 8'h72;

    // Mode register values
    localparam logic MODE_ESCAPE   = 1'b0;
    localparam logic MODE_UNESCAPE = 1'b1;

    // Result counts per item
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

    // Decoded results of one input item
    typedef struct packed {
        logic [1:0] cnt;        // number of result bytes
        logic [7:0] byte0;      // first result byte
        logic [7:0] byte1;      // second result byte, when cnt is two
        logic       field_end;  // item closes the field
        logic       pend_next;  // backslash held after this item
    } t_dec;

endpackage

@@ rtl/core/tsv_field_escape_codec.sv @@
// Top level of the TSV field escape codec: input register, decode, result buffer.
// Depends on tsvfe_pkg and tsvfe_decode.
`timescale 1ns / 1ps
//
// Usage:
//   Slave stream (i_s_*) takes one byte of a text field per item, with tlast on
//   the field's last byte. Master stream (o_m_*) gives the converted bytes; tlast
//   marks the final byte of the field, tuser marks the last byte produced by one
//   input item. The cfg channel writes the mode bit: 0 escapes backslash, tab,
//   newline, carriage return and '#', 1 undoes it. A mode write drops any held
//   backslash; write it only with the block empty.
//   An accepted item passes the input register, then the result register. One
//   item per cycle is sustained while the receiver is ready and each item
//   yields one byte; an item yielding two bytes holds the single output port
//   until both are taken. A held backslash yields no byte.
//   Reset clears both stages, the held backslash and sets escape mode.
//   When the receiver stalls, the result register holds its bytes and the input
//   register fills, after which o_s_tready drops until the output moves again.
//
module tsv_field_escape_codec (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Slave stream
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tlast,   // in_field_end
    // Master stream
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast,   // out_field_end
    output logic       o_m_tuser,   // [0] out_run_last
    // Configuration write
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data   // mode
);
    import tsvfe_pkg::*;

    logic       r_mode;
    logic       r_pend;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_fend;
    logic [1:0] r_cnt;
    logic [7:0] r_b0;
    logic [7:0] r_b1;
    logic       r_fend;

    logic       out_take;
    logic       res_free;
    logic       res_load;
    logic       in_take;
    logic       cfg_take;
    t_dec       dec;

    tsvfe_decode u_decode (
        .i_mode      (r_mode),
        .i_pend      (r_pend),
        .i_byte      (r_in_byte),
        .i_field_end (r_in_fend),
        .o_dec       (dec)
    );

    // Handshake terms
    assign out_take    = o_m_tvalid && i_m_tready;
    assign res_free    = (r_cnt == CNT_NONE) || ((r_cnt == CNT_ONE) && out_take);
    assign res_load    = r_in_valid && res_free;
    assign o_s_tready  = !r_in_valid || res_free;
    assign in_take     = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign cfg_take    = i_cfg_valid && o_cfg_ready;

    // Drive the output from the result register
    assign o_m_tvalid = (r_cnt != CNT_NONE);
    assign o_m_tdata  = r_b0;
    assign o_m_tuser  = (r_cnt == CNT_ONE);
    assign o_m_tlast  = r_fend && (r_cnt == CNT_ONE);

    // Hold mode and the held backslash
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ESCAPE;
            r_pend <= 1'b0;
        end else if (cfg_take) begin
            r_mode <= i_cfg_data;
            r_pend <= 1'b0;
        end else if (res_load) begin
            r_pend <= dec.pend_next;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (res_load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_s_tdata;
            r_in_fend <= i_s_tlast;
        end
    end

    // Result register: load a decoded item or advance to its second byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= CNT_NONE;
        end else if (res_load) begin
            r_cnt <= dec.cnt;
        end else if (out_take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_b0   <= dec.byte0;
            r_b1   <= dec.byte1;
            r_fend <= dec.field_end;
        end else if (out_take) begin
            r_b0 <= r_b1;
        end
    end

`ifndef NO_ASSERTIONS
    // The result register never claims three bytes
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result count out of range");

    // Escape mode never holds a backslash
    a_pend_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_mode == MODE_UNESCAPE))
        else $error("backslash held in escape mode");

    // A mode write drops the held backslash
    a_cfg_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_take |=> !r_pend)
        else $error("held backslash survived a mode write");

    // Taking the first byte of a pair leaves its second byte waiting
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == CNT_TWO) && out_take |=> (r_cnt == CNT_ONE) || $past(res_load))
        else $error("pair did not advance to its second byte");
`endif

endmodule

@@ rtl/core/tsvfe_decode.sv @@
// Combinational byte translation for one item of the TSV field escape codec.
// Depends on tsvfe_pkg.
`timescale 1ns / 1ps

module tsvfe_decode (
    input  logic              i_mode,
    input  logic              i_pend,
    input  logic [7:0]        i_byte,
    input  logic              i_field_end,
    output tsvfe_pkg::t_dec   o_dec
);
    import tsvfe_pkg::*;

    logic [7:0] esc_code;
    logic       esc_hit;
    logic [7:0] unesc_byte;
    logic       unesc_hit;

    // Map a special byte to its code letter
    always_comb begin
        esc_hit  = 1'b1;
        esc_code = CH_BSL;
        case (i_byte)
            CH_BSL:  esc_code = CH_BSL;
            CH_TAB:  esc_code = CH_T;
            CH_LF:   esc_code = CH_N;
            CH_CR:   esc_code = CH_R;
            CH_HASH: esc_code = CH_HASH;
            default: esc_hit  = 1'b0;
        endcase
    end

    // Map a code letter back to its byte
    always_comb begin
        unesc_hit  = 1'b1;
        unesc_byte = CH_BSL;
        case (i_byte)
            CH_BSL:  unesc_byte = CH_BSL;
            CH_T:    unesc_byte = CH_TAB;
            CH_N:    unesc_byte = CH_LF;
            CH_R:    unesc_byte = CH_CR;
            CH_HASH: unesc_byte = CH_HASH;
            default: unesc_hit  = 1'b0;
        endcase
    end

    // Choose the results for this item
    always_comb begin
        o_dec.field_end = i_field_end;
        o_dec.pend_next = 1'b0;
        o_dec.byte1     = i_byte;
        o_dec.byte0     = i_byte;
        o_dec.cnt       = CNT_ONE;
        if (i_mode == MODE_ESCAPE) begin
            if (esc_hit) begin
                o_dec.cnt   = CNT_TWO;
                o_dec.byte0 = CH_BSL;
                o_dec.byte1 = esc_code;
            end
        end else if (i_pend) begin
            if (unesc_hit) begin
                o_dec.byte0 = unesc_byte;
            end else begin
                o_dec.cnt   = CNT_TWO;
                o_dec.byte0 = CH_BSL;
            end
        end else if (i_byte == CH_BSL && !i_field_end) begin
            o_dec.cnt       = CNT_NONE;
            o_dec.pend_next = 1'b1;
        end
    end

endmodule
